// File: design/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int KEY_BITS   = 32;
  localparam int NODE_W     = 10;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;

  typedef enum logic [1:0] {
    KIND_UPSERT   = 2'd0,
    KIND_INCREASE = 2'd1,
    KIND_EXTRACT  = 2'd2,
    KIND_PROBE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,      // clearing pass over the location table
    S_IDLE,
    S_LOC,       // location table read issued
    S_DECIDE,
    S_CLR,       // clear location of extracted node
    S_LASTRD,    // read last slot
    S_MOVE,      // move last to root
    S_UPRD,      // read parent
    S_UPCMP,
    S_DNRDL,     // read left child
    S_DNRDR,     // read right child
    S_DNCMP,
    S_SWAP,      // write first half of swap
    S_SWAP2,
    S_ROOTRD,
    S_ROOTWT,
    S_DONE
  } state_t;

  // location table entry: present bit and slot
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } loc_t;

  // slot memory word
  typedef struct packed {
    logic [KEY_BITS-1:0] value;
    logic [NODE_W-1:0]   node;
  } ent_t;

endpackage

// File: design/imhq_loc.sv
// ----------------------------------------------------------------------------
// imhq_loc
// Node-to-slot location table; present bit and slot per node in one memory.
// ----------------------------------------------------------------------------
module imhq_loc (
  input  logic                        clk,
  input  logic [imhq_pkg::NODE_W-1:0] raddr,
  output imhq_pkg::loc_t              rdata,
  input  logic                        we,
  input  logic [imhq_pkg::NODE_W-1:0] waddr,
  input  imhq_pkg::loc_t              wdata
);
  import imhq_pkg::*;

  loc_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/imhq_heap_ram.sv
// ----------------------------------------------------------------------------
// imhq_heap_ram
// Heap slot storage: value and node per slot, one write and one read port.
// ----------------------------------------------------------------------------
module imhq_heap_ram (
  input  logic                        clk,
  input  logic [imhq_pkg::SLOT_W-1:0] raddr,
  output imhq_pkg::ent_t              rdata,
  input  logic                        we,
  input  logic [imhq_pkg::SLOT_W-1:0] waddr,
  input  imhq_pkg::ent_t              wdata
);
  import imhq_pkg::*;

  ent_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/indexed_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_core
// Indexed binary min-heap with insert/update, increase, extract and probe.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | in        | in_valid / in_stall  (kind, node, value)
// out     | out       | out_valid / out_stall (status .. entry_count)
//
// One word at a time: in_stall stays high from acceptance until the result
// leaves the output register. Probe, increase of an absent node and extract
// on an empty heap go from the location read straight to the root read; a
// sift climbs one level per parent read, compare and swap, and descends one
// level per left read, right read, compare and swap (one slot RAM read port,
// one write port). Worst case is an extract on a full heap. After reset a
// clearing pass marks all 1024 location entries absent (in_stall high).
// out_stall only holds the output register.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [9:0]  node,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        was_present,
  output logic [9:0]  taken_node,
  output logic [31:0] taken_value,
  output logic [9:0]  top_node,
  output logic [31:0] top_value,
  output logic        heap_empty,
  output logic [10:0] entry_count
);
  import imhq_pkg::*;

  state_t state, state_next;

  logic [1:0]          op_kind;
  logic [NODE_W-1:0]   op_node;
  logic [KEY_BITS-1:0] op_value;
  logic [CNT_W-1:0]    occ;
  logic [SLOT_W-1:0]   cur;        // slot being sifted
  ent_t                cur_ent;
  ent_t                oth_ent;    // parent or chosen child
  logic [SLOT_W-1:0]   oth;
  ent_t                lft_ent;
  logic                up_phase;
  logic                down_after; // update: sift down once the climb ends
  logic                present;
  status_t             st;
  logic [NODE_W-1:0]   clr_addr;

  // memory ports
  logic [NODE_W-1:0] loc_raddr, loc_waddr;
  loc_t              loc_rdata, loc_wdata;
  logic              loc_we;
  logic [SLOT_W-1:0] h_raddr, h_waddr;
  ent_t              h_rdata, h_wdata;
  logic              h_we;

  imhq_loc u_loc (
    .clk, .raddr(loc_raddr), .rdata(loc_rdata),
    .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata)
  );

  imhq_heap_ram u_ram (
    .clk, .raddr(h_raddr), .rdata(h_rdata),
    .we(h_we), .waddr(h_waddr), .wdata(h_wdata)
  );

  logic [CNT_W-1:0] lidx, ridx;
  logic [SLOT_W-1:0] par;
  assign lidx = {cur, 1'b1};
  assign ridx = lidx + CNT_W'(1);
  assign par  = SLOT_W'((cur - SLOT_W'(1)) >> 1);

  logic loc_ok;
  assign loc_ok = loc_rdata.vld && ({1'b0, loc_rdata.slot} < occ);

  // h_rdata is the parent in S_UPCMP and the right child in S_DNCMP
  logic up_swap, dn_right, dn_swap;
  assign up_swap  = h_rdata.value > cur_ent.value;
  assign dn_right = (ridx < occ) && (h_rdata.value < lft_ent.value)
                    && (cur_ent.value > h_rdata.value);
  assign dn_swap  = (cur_ent.value > lft_ent.value)
                    || ((ridx < occ) && (cur_ent.value > h_rdata.value));

  assign in_stall = (state != S_IDLE) || out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (clr_addr == NODE_W'(NODE_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid && !in_stall) state_next = S_LOC;
      S_LOC:    state_next = S_DECIDE;
      S_DECIDE: begin
        if (op_kind == KIND_EXTRACT) begin
          state_next = (occ == '0) ? S_ROOTRD : S_CLR;
        end else if (op_kind == KIND_PROBE) begin
          state_next = S_ROOTRD;
        end else if (loc_ok) begin
          state_next = S_UPRD;
        end else if (op_kind == KIND_UPSERT && occ < CNT_W'(NODE_COUNT)) begin
          state_next = S_UPRD;
        end else begin
          state_next = S_ROOTRD;
        end
      end
      S_CLR:    state_next = S_LASTRD;
      S_LASTRD: state_next = (occ == '0) ? S_ROOTRD : S_MOVE;
      S_MOVE:   state_next = S_DNRDL;
      S_UPRD:   state_next = (cur == '0) ? (down_after ? S_DNRDL : S_ROOTRD) : S_UPCMP;
      S_UPCMP:  begin
        if (up_swap) state_next = S_SWAP;
        else state_next = down_after ? S_DNRDL : S_ROOTRD;
      end
      S_DNRDL:  state_next = (lidx >= occ) ? S_ROOTRD : S_DNRDR;
      S_DNRDR:  state_next = S_DNCMP;
      S_DNCMP:  state_next = dn_swap ? S_SWAP : S_ROOTRD;
      S_SWAP:   state_next = S_SWAP2;
      S_SWAP2:  state_next = up_phase ? S_UPRD : S_DNRDL;
      S_ROOTRD: state_next = S_ROOTWT;
      S_ROOTWT: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    loc_raddr = op_node;
    loc_we    = 1'b0;
    loc_waddr = op_node;
    loc_wdata = '{vld: 1'b1, slot: cur};
    h_raddr   = cur;
    h_we      = 1'b0;
    h_waddr   = cur;
    h_wdata   = cur_ent;
    unique case (state)
      S_INIT: begin
        loc_we    = 1'b1;
        loc_waddr = clr_addr;
        loc_wdata = '{vld: 1'b0, slot: '0};
      end
      S_IDLE:   loc_raddr = node;
      S_DECIDE: h_raddr = '0;
      S_CLR: begin
        loc_we    = 1'b1;
        loc_waddr = h_rdata.node;
        loc_wdata = '{vld: 1'b0, slot: '0};
        h_raddr   = occ[SLOT_W-1:0];
      end
      S_LASTRD: h_raddr = occ[SLOT_W-1:0];
      S_MOVE: begin
        h_we      = 1'b1;
        h_waddr   = '0;
        h_wdata   = h_rdata;
        loc_we    = 1'b1;
        loc_waddr = h_rdata.node;
        loc_wdata = '{vld: 1'b1, slot: '0};
      end
      S_UPRD: begin
        // (re)write the moving entry at its current slot
        h_raddr   = par;
        h_we      = 1'b1;
        h_waddr   = cur;
        h_wdata   = cur_ent;
        loc_we    = 1'b1;
        loc_waddr = cur_ent.node;
        loc_wdata = '{vld: 1'b1, slot: cur};
      end
      S_DNRDL:  h_raddr = lidx[SLOT_W-1:0];
      S_DNRDR:  h_raddr = ridx[SLOT_W-1:0];
      S_SWAP: begin
        h_we      = 1'b1;
        h_waddr   = cur;
        h_wdata   = oth_ent;
        loc_we    = 1'b1;
        loc_waddr = oth_ent.node;
        loc_wdata = '{vld: 1'b1, slot: cur};
      end
      S_SWAP2: begin
        h_we      = 1'b1;
        h_waddr   = oth;
        h_wdata   = cur_ent;
        loc_we    = 1'b1;
        loc_waddr = cur_ent.node;
        loc_wdata = '{vld: 1'b1, slot: oth};
      end
      S_ROOTRD: h_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_addr  <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) clr_addr <= clr_addr + NODE_W'(1);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == S_DONE) out_valid <= 1'b1;
      if (state == S_DECIDE && op_kind == KIND_EXTRACT && occ != '0)
        occ <= occ - CNT_W'(1);
      if (state == S_DECIDE && op_kind == KIND_UPSERT && !loc_ok
          && occ < CNT_W'(NODE_COUNT))
        occ <= occ + CNT_W'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          op_kind     <= kind;
          op_node     <= node;
          op_value    <= value;
          st          <= ST_OK;
          present     <= 1'b0;
          taken_node  <= '0;
          taken_value <= '0;
        end
      end
      S_DECIDE: begin
        up_phase   <= 1'b1;
        down_after <= loc_ok;
        if (op_kind == KIND_EXTRACT) begin
          if (occ == '0) st <= ST_EMPTY;
        end else begin
          present <= loc_ok;
          if (loc_ok) begin
            cur     <= loc_rdata.slot;
            cur_ent <= '{value: op_value, node: op_node};
          end else if (op_kind == KIND_INCREASE) begin
            st <= ST_ABSENT;
          end else begin
            cur     <= occ[SLOT_W-1:0];
            cur_ent <= '{value: op_value, node: op_node};
          end
        end
      end
      S_CLR: begin
        taken_node  <= h_rdata.node;
        taken_value <= h_rdata.value;
      end
      S_MOVE: begin
        cur      <= '0;
        cur_ent  <= h_rdata;
        up_phase <= 1'b0;
      end
      S_UPRD: begin
        oth <= par;
        if (cur == '0) up_phase <= 1'b0;
      end
      S_UPCMP: begin
        oth_ent <= h_rdata;
        if (!up_swap) up_phase <= 1'b0;
      end
      S_DNRDR: lft_ent <= h_rdata;
      S_DNCMP: begin
        if (dn_right) begin
          oth_ent <= h_rdata;
          oth     <= ridx[SLOT_W-1:0];
        end else begin
          oth_ent <= lft_ent;
          oth     <= lidx[SLOT_W-1:0];
        end
      end
      S_SWAP2: cur <= oth;
      S_ROOTWT: begin
        top_node  <= (occ == '0) ? '0 : h_rdata.node;
        top_value <= (occ == '0) ? '0 : h_rdata.value;
      end
      default: ;
    endcase
  end

  assign status      = st;
  assign was_present = present;
  assign heap_empty  = (occ == '0);
  assign entry_count = occ;
endmodule

// File: design/imhq_checker.sv
// ----------------------------------------------------------------------------
// imhq_checker
// Port-level checks on the heap queue.
// ----------------------------------------------------------------------------
module imhq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        heap_empty,
  input logic [10:0] entry_count
);
  import imhq_pkg::*;

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heap_empty == (entry_count == 11'd0))) else $error("empty flag");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("not busy after accept");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_ABSENT))
    else $error("bad status");
endmodule

bind indexed_min_heap_queue_core imhq_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .heap_empty, .entry_count
);
